/* src/adaptive_row_prediction_filter_unit_macros.svh */
// Assertion macros for the adaptive row prediction filter.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef ADAPTIVE_ROW_PREDICTION_FILTER_UNIT_MACROS_SVH
`define ADAPTIVE_ROW_PREDICTION_FILTER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ARPF_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ARPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ARPF_ASSERT_IMPLY(lbl, ante, cons, msg)
`define ARPF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* src/arpf_pkg.sv */
// Shared types, constants and predictor functions of the row prediction filter.
// No dependencies.
`timescale 1ns / 1ps
package arpf_pkg;

    localparam int OUT_DEPTH = 16;
    localparam int OUT_PW    = 4;
    localparam int CNT_W     = 5;

    localparam int COST_W  = 18;
    localparam int SCALE_W = 19;
    localparam logic [COST_W-1:0] COST_MAX = 18'h3FFFF;

    // floor(c*85/100) and floor(c*115/100) as c*K >> 32, K = 85 or 115 times ceil(2^32/100)
    localparam logic [32:0] C85  = 33'd3650722205;
    localparam logic [32:0] C115 = 33'd4939212395;

    localparam logic        REG_ROW_WIDTH   = 1'b0;
    localparam logic [12:0] ROW_WIDTH_RESET = 13'd256;

    localparam logic KIND_PIXEL    = 1'b0;
    localparam logic KIND_DRAIN    = 1'b1;
    localparam logic ITEM_RESIDUAL = 1'b0;
    localparam logic ITEM_MODE     = 1'b1;

    typedef enum logic [1:0] {
        ROW_IDLE    = 2'd0,
        ROW_FIRST   = 2'd1,
        ROW_PENDING = 2'd2,
        ROW_DRAIN   = 2'd3
    } t_row_phase;

    typedef enum logic [2:0] {
        MODE_NONE  = 3'd0,
        MODE_LEFT  = 3'd1,
        MODE_UP    = 3'd2,
        MODE_AVG   = 3'd3,
        MODE_PAETH = 3'd4
    } t_mode;

    typedef struct packed {
        logic       item_type;
        logic [7:0] value;
        logic       last_of_run;
        logic       last_of_frame;
    } t_result;

    typedef struct packed {
        logic    v0;
        t_result d0;
        logic    v1;
        t_result d1;
    } t_push;

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Paeth estimate wraps to 8 bits
    function automatic logic [7:0] predict(input t_mode mode, input logic [7:0] lf,
                                           input logic [7:0] up, input logic [7:0] ul);
        logic [7:0] est;
        logic [7:0] dl;
        logic [7:0] du;
        logic [7:0] dul;
        logic [8:0] sum;
        est = lf + up - ul;
        dl  = absdiff8(est, lf);
        du  = absdiff8(est, up);
        dul = absdiff8(est, ul);
        sum = {1'b0, lf} + {1'b0, up};
        unique case (mode)
            MODE_LEFT:  predict = lf;
            MODE_UP:    predict = up;
            MODE_AVG:   predict = sum[8:1];
            MODE_PAETH: begin
                if (dl <= du) predict = (dl <= dul) ? lf : ul;
                else          predict = (du <= dul) ? up : ul;
            end
            default:    predict = 8'd0;
        endcase
    endfunction

endpackage

/* src/arpf_in_if.sv */
// Input channel of the row prediction filter: valid/ready plus item payload.
// No dependencies.
`timescale 1ns / 1ps
interface arpf_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] pixel;
    logic       first_of_frame;

    modport source (output valid, kind, pixel, first_of_frame, input ready);
    modport sink   (input valid, kind, pixel, first_of_frame, output ready);
endinterface

/* src/arpf_out_if.sv */
// Result channel of the row prediction filter: valid/ready plus result payload.
// No dependencies.
`timescale 1ns / 1ps
interface arpf_out_if;
    logic       valid;
    logic       ready;
    logic       item_type;
    logic [7:0] value;
    logic       last_of_run;
    logic       last_of_frame;

    modport source (output valid, item_type, value, last_of_run, last_of_frame, input ready);
    modport sink   (input valid, item_type, value, last_of_run, last_of_frame, output ready);
endinterface

/* src/arpf_out_fifo.sv */
// Result FIFO: takes up to two results a cycle, hands out one.
// Depends on arpf_pkg and arpf_out_if.
`timescale 1ns / 1ps
module arpf_out_fifo import arpf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_push            i_push,
    output logic [CNT_W-1:0] o_count,
    arpf_out_if.source       o_out
);
    t_result           r_mem [OUT_DEPTH];
    logic [OUT_PW-1:0] r_wp, n_wp;
    logic [OUT_PW-1:0] r_rp, n_rp;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              w_pop;
    t_result           w_head;

    assign w_head          = r_mem[r_rp];
    assign o_out.valid     = (r_count != '0);
    assign o_out.item_type = w_head.item_type;
    assign o_out.value     = w_head.value;
    assign o_out.last_of_run   = w_head.last_of_run;
    assign o_out.last_of_frame = w_head.last_of_frame;
    assign o_count         = r_count;
    assign w_pop           = o_out.valid & o_out.ready;

    always_comb begin
        n_wp    = r_wp + OUT_PW'(i_push.v0) + OUT_PW'(i_push.v1);
        n_rp    = r_rp + OUT_PW'(w_pop);
        n_count = r_count + CNT_W'(i_push.v0) + CNT_W'(i_push.v1) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) r_mem[r_wp] <= i_push.d0;
        if (i_push.v1) r_mem[r_wp + OUT_PW'(1)] <= i_push.d1;
    end
endmodule

/* src/adaptive_row_prediction_filter_unit.sv */
// Adaptive row prediction filter, top level. Throughput: one item per cycle while the
// result FIFO has room for everything in flight; a row's first pixel yields two results.
// An accepted item passes the registers r_p1, r_p2 and r_p3, then the result FIFO.
// The row store does two reads (pending row, row above it) and one write per cycle.
// Synchronous active-low reset clears control, costs and mode; the row store has no reset
// and needs no clearing pass, since every entry is written before it is read.
`timescale 1ns / 1ps
`include "adaptive_row_prediction_filter_unit_macros.svh"
module adaptive_row_prediction_filter_unit import arpf_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    arpf_in_if.sink     i_in,
    arpf_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] BASE1 = AW'(MAX_WIDTH);
    localparam logic [AW-1:0] BASE2 = AW'(2 * MAX_WIDTH);

    // ---------------- configuration ----------------
    logic [12:0]   r_row_width;
    logic          w_cfg_wr;
    logic [WW-1:0] w_eff;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & (paddr[2] == REG_ROW_WIDTH);
    assign prdata   = (paddr[2] == REG_ROW_WIDTH) ? {19'd0, r_row_width} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_row_width <= ROW_WIDTH_RESET;
        else if (w_cfg_wr) r_row_width <= pwdata[12:0];
    end

    // width 0 acts as 1, anything above MAX_WIDTH as MAX_WIDTH
    always_comb begin
        if (r_row_width == 13'd0) w_eff = WW'(1);
        else if (32'(r_row_width) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
        else w_eff = WW'(r_row_width);
    end

    // ---------------- row sequencer ----------------
    typedef struct packed {
        logic       valid;
        logic       emit;
        logic       emit_mode;
        logic       do_cost;
        logic       eor;
        logic       choose;
        logic       lastf;
        logic       col0;
        logic [7:0] pix;
        logic [7:0] lf;
    } t_s1;

    typedef struct packed {
        logic       valid;
        logic       emit;
        logic       emit_mode;
        logic       eor;
        logic       choose;
        logic       lastf;
        logic       col0;
        logic [7:0] v;
        logic [7:0] rl;
        logic [7:0] ru;
        logic [7:0] rul;
    } t_s2;

    t_row_phase    r_phase, n_phase, w_phase_e;
    logic [CW-1:0] r_col, n_col, w_col_e;
    logic [CW:0]   w_col_inc;
    logic [1:0]    r_rot, n_rot;
    logic [7:0]    r_lastpix;
    logic          w_acc, w_pixel, w_end_row;
    logic          w_emit, w_emit_mode, w_do_cost, w_lastf, w_wr_en;
    t_s1           r_p1;
    t_s2           r_p2, r_p3;
    logic [CNT_W-1:0] w_count;
    logic [CNT_W:0]   w_reserve;

    assign w_pixel = (i_in.kind == KIND_PIXEL);
    assign w_acc   = i_in.valid & i_in.ready;

    // ready holds room in the FIFO for everything in flight, two results per item
    assign w_reserve = (CNT_W+1)'(w_count) + (CNT_W+1)'({r_p1.valid, 1'b0})
                     + (CNT_W+1)'({r_p2.valid, 1'b0}) + (CNT_W+1)'({r_p3.valid, 1'b0});
    assign i_in.ready = (w_reserve <= (CNT_W+1)'(OUT_DEPTH - 2));

    // effective phase and column once restarts and drain entry are applied
    always_comb begin
        w_phase_e = r_phase;
        w_col_e   = r_col;
        if (w_pixel) begin
            if (i_in.first_of_frame || r_phase == ROW_IDLE || r_phase == ROW_DRAIN) begin
                w_phase_e = ROW_FIRST;
                w_col_e   = '0;
            end
        end else if (r_phase == ROW_PENDING && r_col == '0) begin
            w_phase_e = ROW_DRAIN;
        end
    end

    assign w_col_inc = {1'b0, w_col_e} + (CW+1)'(1);
    assign w_end_row = (32'(w_col_inc) >= 32'(w_eff));

    // decode of the item's work
    always_comb begin
        w_emit    = 1'b0;
        w_do_cost = 1'b0;
        w_lastf   = 1'b0;
        w_wr_en   = 1'b0;
        if (w_pixel) begin
            w_wr_en   = 1'b1;
            w_emit    = (w_phase_e == ROW_PENDING);
            w_do_cost = w_emit && (w_col_e[2:0] == 3'd4);
        end else begin
            w_emit  = (w_phase_e == ROW_DRAIN);
            w_lastf = w_emit & w_end_row;
        end
        w_emit_mode = w_emit && (w_col_e == '0);
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_col   = r_col;
        n_rot   = r_rot;
        if (w_acc) begin
            if (w_pixel) begin
                if (w_end_row) begin
                    n_col   = '0;
                    n_rot   = (r_rot == 2'd2) ? 2'd0 : r_rot + 2'd1;
                    n_phase = ROW_PENDING;
                end else begin
                    n_col   = w_col_inc[CW-1:0];
                    n_phase = w_phase_e;
                end
            end else if (w_phase_e == ROW_DRAIN) begin
                if (w_end_row) begin
                    n_col   = '0;
                    n_phase = ROW_IDLE;
                end else begin
                    n_col   = w_col_inc[CW-1:0];
                    n_phase = ROW_DRAIN;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ROW_IDLE;
            r_col   <= '0;
            r_rot   <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_col   <= n_col;
            r_rot   <= n_rot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_pixel) r_lastpix <= i_in.pixel;
    end

    // ---------------- row store ----------------
    // three rotating rows: current (rot), pending (rot+2), above pending (rot+1)
    function automatic logic [AW-1:0] row_base(input logic [1:0] row);
        unique case (row)
            2'd0:    row_base = '0;
            2'd1:    row_base = BASE1;
            2'd2:    row_base = BASE2;
            default: row_base = '0;
        endcase
    endfunction

    logic [1:0]    w_prow, w_qrow;
    logic [AW-1:0] w_wa, w_pa, w_qa;
    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_qp, r_qq;

    always_comb begin
        unique case (r_rot)
            2'd0:    begin w_prow = 2'd2; w_qrow = 2'd1; end
            2'd1:    begin w_prow = 2'd0; w_qrow = 2'd2; end
            2'd2:    begin w_prow = 2'd1; w_qrow = 2'd0; end
            default: begin w_prow = 2'd2; w_qrow = 2'd1; end
        endcase
    end

    assign w_wa = row_base(r_rot)  + AW'(w_col_e);
    assign w_pa = row_base(w_prow) + AW'(w_col_e);
    assign w_qa = row_base(w_qrow) + AW'(w_col_e);

    always_ff @(posedge i_clk) begin
        if (w_acc && w_wr_en) r_mem[w_wa] <= i_in.pixel;
        if (w_acc) begin
            r_qp <= r_mem[w_pa];
            r_qq <= r_mem[w_qa];
        end
    end

    // ---------------- stage 1: cost accumulation ----------------
    logic [COST_W-1:0] r_cost [5];
    logic [COST_W-1:0] w_upd  [5];
    logic [COST_W-1:0] r_fin  [5];
    logic [7:0]        r_pp, r_pq;   // pending row and row above at col-1

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= '0;
        end else begin
            r_p1.valid     <= w_acc;
            r_p1.emit      <= w_emit;
            r_p1.emit_mode <= w_emit_mode;
            r_p1.do_cost   <= w_do_cost;
            r_p1.eor       <= w_pixel & w_end_row;
            r_p1.choose    <= (w_phase_e == ROW_PENDING);
            r_p1.lastf     <= w_lastf;
            r_p1.col0      <= (w_col_e == '0);
            r_p1.pix       <= i_in.pixel;
            r_p1.lf        <= r_lastpix;
        end
    end

    always_comb begin
        logic [7:0]        pr;
        logic [COST_W:0]   sum;
        for (int m = 0; m < 5; m++) begin
            pr  = predict(t_mode'(3'(m)), r_p1.lf, r_qp, r_pp);
            sum = {1'b0, r_cost[m]} + (COST_W+1)'(absdiff8(r_p1.pix, pr));
            if (r_p1.valid && r_p1.do_cost)
                w_upd[m] = (sum > {1'b0, COST_MAX}) ? COST_MAX : sum[COST_W-1:0];
            else
                w_upd[m] = r_cost[m];
        end
    end

    // costs restart at each row end; the final sums move on for scaling
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < 5; m++) r_cost[m] <= '0;
        end else begin
            for (int m = 0; m < 5; m++)
                r_cost[m] <= (r_p1.valid && r_p1.eor) ? '0 : w_upd[m];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1.valid && r_p1.eor) begin
            for (int m = 0; m < 5; m++) r_fin[m] <= w_upd[m];
        end
        if (r_p1.valid && r_p1.emit) begin
            r_pp <= r_qp;
            r_pq <= r_qq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2 <= '0;
        end else begin
            r_p2.valid     <= r_p1.valid;
            r_p2.emit      <= r_p1.emit;
            r_p2.emit_mode <= r_p1.emit_mode;
            r_p2.eor       <= r_p1.eor;
            r_p2.choose    <= r_p1.choose;
            r_p2.lastf     <= r_p1.lastf;
            r_p2.col0      <= r_p1.col0;
            r_p2.v         <= r_qp;
            r_p2.rl        <= r_pp;
            r_p2.ru        <= r_qq;
            r_p2.rul       <= r_pq;
        end
    end

    // ---------------- stage 2: cost scaling ----------------
    // r_mode still holds the previous row's choice here: rows shorter than five
    // pixels never add cost, so a mode write still in flight cannot matter.
    t_mode              r_mode;
    logic [COST_W-1:0]  w_fin_prev;
    logic [50:0]        w_prod85, w_prod115;
    logic [SCALE_W-1:0] r_s85, r_s115;
    logic [COST_W-1:0]  r_fin2 [5];

    always_comb begin
        unique case (r_mode)
            MODE_NONE:  w_fin_prev = r_fin[0];
            MODE_LEFT:  w_fin_prev = r_fin[1];
            MODE_UP:    w_fin_prev = r_fin[2];
            MODE_AVG:   w_fin_prev = r_fin[3];
            MODE_PAETH: w_fin_prev = r_fin[4];
            default:    w_fin_prev = '0;
        endcase
    end

    assign w_prod85  = 51'(w_fin_prev) * 51'(C85);
    assign w_prod115 = 51'(r_fin[4])   * 51'(C115);

    always_ff @(posedge i_clk) begin
        if (r_p2.valid && r_p2.eor) begin
            r_s85  <= w_prod85[50:32];
            r_s115 <= w_prod115[50:32];
            for (int m = 0; m < 5; m++) r_fin2[m] <= r_fin[m];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p3 <= '0;
        else          r_p3 <= r_p2;
    end

    // ---------------- stage 3: mode choice and residual ----------------
    logic [SCALE_W-1:0] w_sc [5];
    t_mode              w_best;
    logic [SCALE_W-1:0] w_bd;
    logic [7:0]         w_resid;
    t_push              w_push;
    t_result            w_mode_item, w_res_item;

    always_comb begin
        for (int m = 0; m < 5; m++) begin
            if (3'(m) == r_mode)  w_sc[m] = r_s85;
            else if (m == 4)      w_sc[m] = r_s115;
            else                  w_sc[m] = {1'b0, r_fin2[m]};
        end
    end

    // lowest scaled cost, lower mode on ties
    always_comb begin
        w_best = MODE_NONE;
        w_bd   = w_sc[0];
        for (int m = 1; m < 5; m++) begin
            if (w_sc[m] < w_bd) begin
                w_bd   = w_sc[m];
                w_best = t_mode'(3'(m));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= MODE_NONE;
        else if (r_p3.valid && r_p3.eor) r_mode <= r_p3.choose ? w_best : MODE_NONE;
    end

    // column 0 predicts from the row above
    always_comb begin
        if (r_mode == MODE_NONE) w_resid = r_p3.v;
        else if (r_p3.col0)      w_resid = r_p3.v - r_p3.ru;
        else w_resid = r_p3.v - predict(r_mode, r_p3.rl, r_p3.ru, r_p3.rul);
    end

    always_comb begin
        w_mode_item = '{item_type: ITEM_MODE, value: {5'd0, r_mode},
                        last_of_run: 1'b0, last_of_frame: 1'b0};
        w_res_item  = '{item_type: ITEM_RESIDUAL, value: w_resid,
                        last_of_run: 1'b1, last_of_frame: r_p3.lastf};
        w_push = '0;
        if (r_p3.valid && r_p3.emit) begin
            if (r_p3.emit_mode) begin
                w_push.v0 = 1'b1;
                w_push.d0 = w_mode_item;
                w_push.v1 = 1'b1;
                w_push.d1 = w_res_item;
            end else begin
                w_push.v0 = 1'b1;
                w_push.d0 = w_res_item;
            end
        end
    end

    arpf_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_count (w_count),
        .o_out   (o_out)
    );

    // ---------------- checks ----------------
    `ARPF_ASSERT_NEXT(a_mode_range, r_p3.valid && r_p3.eor, r_mode <= MODE_PAETH, "mode out of range")
    `ARPF_ASSERT_IMPLY(a_fifo_bound, 1'b1, w_count <= CNT_W'(OUT_DEPTH), "result FIFO overflow")
    `ARPF_ASSERT_IMPLY(a_pair_order, w_push.v1, w_push.v0 && w_push.d0.item_type == ITEM_MODE, "pair order")
endmodule

/* sim/tb.sv */
// Testbench for adaptive_row_prediction_filter_unit: streams frames of pixels and drain
// items, predicts every result with an in-bench filter model and checks each one.
// Depends on arpf_pkg, arpf_in_if, arpf_out_if and the filter top level.
`timescale 1ns / 1ps
module tb;
    import arpf_pkg::*;

    localparam int MAXW      = 4096;
    localparam int WD_LIMIT  = 20000;
    localparam int SETTLE    = 20;   // extra wait after the queues have emptied

    typedef struct {
        logic       kind;
        logic [7:0] pixel;
        logic       first;
    } t_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    arpf_in_if  in_ch ();
    arpf_out_if out_ch ();

    adaptive_row_prediction_filter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    // ---------------- filter model ----------------
    logic [7:0]  row_mem [0:3*MAXW-1];
    int unsigned cfg_width;
    int unsigned col_pos;
    t_row_phase  phase;
    int unsigned cost [5];
    t_mode       pend_mode;
    t_mode       prev_mode;
    int unsigned rot;

    t_item   pixel_q [$];
    t_result result_q [$];
    int      fail_cnt = 0;
    bit      no_gaps = 1'b0;

    function automatic int unsigned eff_width();
        int unsigned w;
        w = cfg_width & 13'h1FFF;
        if (w < 1) w = 1;
        if (w > MAXW) w = MAXW;
        return w;
    endfunction

    function automatic logic [7:0] mem_rd(int unsigned buf_i, int unsigned c);
        if (c >= MAXW) return 8'd0;
        return row_mem[(buf_i % 3) * MAXW + c];
    endfunction

    function automatic logic [7:0] adiff(logic [7:0] a, logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [7:0] estimate(t_mode m, logic [7:0] lf, logic [7:0] up,
                                            logic [7:0] ul);
        logic [7:0] est, dl, du, dul;
        logic [8:0] s;
        est = lf + up - ul;   // wraps to 8 bits
        dl = adiff(est, lf);
        du = adiff(est, up);
        dul = adiff(est, ul);
        s = {1'b0, lf} + {1'b0, up};
        case (m)
            MODE_LEFT:  return lf;
            MODE_UP:    return up;
            MODE_AVG:   return s[8:1];
            MODE_PAETH: begin
                if (dl <= du) return (dl <= dul) ? lf : ul;
                return (du <= dul) ? up : ul;
            end
            default:    return 8'd0;
        endcase
    endfunction

    // residual of the row waiting for output, at column c
    function automatic logic [7:0] residual_at(int unsigned c);
        int unsigned pr, qr;
        logic [7:0] v;
        pr = (rot + 2) % 3;
        qr = (rot + 1) % 3;
        v = mem_rd(pr, c);
        if (pend_mode == MODE_NONE) return v;
        if (c == 0) return v - mem_rd(qr, 0);
        return v - estimate(pend_mode, mem_rd(pr, c - 1), mem_rd(qr, c), mem_rd(qr, c - 1));
    endfunction

    function automatic int unsigned weighted(int m);
        if (m == int'(prev_mode)) return cost[m] * 85 / 100;
        if (m == int'(MODE_PAETH)) return cost[m] * 115 / 100;
        return cost[m];
    endfunction

    function automatic t_mode pick_mode();
        int unsigned bestc, s;
        t_mode best;
        best = MODE_NONE;
        bestc = weighted(0);
        for (int m = 1; m < 5; m++) begin
            s = weighted(m);
            if (s < bestc) begin
                bestc = s;
                best = t_mode'(m);
            end
        end
        return best;
    endfunction

    function automatic void add_result(logic ty, logic [7:0] v, logic lf);
        t_result r;
        r.item_type = ty;
        r.value = v;
        r.last_of_run = 1'b0;
        r.last_of_frame = lf;
        result_q.push_back(r);
    endfunction

    function automatic void model_reset();
        cfg_width = ROW_WIDTH_RESET;
        col_pos = 0;
        phase = ROW_IDLE;
        foreach (cost[m]) cost[m] = 0;
        pend_mode = MODE_NONE;
        prev_mode = MODE_NONE;
        rot = 0;
    endfunction

    // one accepted item: update state, queue expected results
    function automatic void filter_item(t_item it);
        int unsigned w, c, cr, pr, q_mark, s;
        logic [7:0] lf, up, ul;
        logic endrow;
        w = eff_width();
        c = col_pos;
        q_mark = result_q.size();
        if (it.kind == KIND_PIXEL) begin
            if (it.first || phase == ROW_IDLE || phase == ROW_DRAIN) begin
                phase = ROW_FIRST;
                c = 0;
                pend_mode = MODE_NONE;
                prev_mode = MODE_NONE;
                foreach (cost[m]) cost[m] = 0;
            end
            cr = rot % 3;
            pr = (rot + 2) % 3;
            if (phase == ROW_PENDING) begin
                if (c == 0) add_result(ITEM_MODE, 8'(pend_mode), 1'b0);
                add_result(ITEM_RESIDUAL, residual_at(c), 1'b0);
            end
            if (c < MAXW) row_mem[cr * MAXW + c] = it.pixel;
            // cost sampled at x = 4, 12, 20, ...
            if (phase == ROW_PENDING && (c & 7) == 4) begin
                lf = mem_rd(cr, c - 1);
                up = mem_rd(pr, c);
                ul = mem_rd(pr, c - 1);
                for (int m = 0; m < 5; m++) begin
                    s = cost[m] + adiff(it.pixel, estimate(t_mode'(m), lf, up, ul));
                    cost[m] = (s > COST_MAX) ? COST_MAX : s;
                end
            end
            if (c + 1 >= w) begin
                pend_mode = (phase == ROW_PENDING) ? pick_mode() : MODE_NONE;
                prev_mode = pend_mode;
                foreach (cost[m]) cost[m] = 0;
                c = 0;
                rot = (rot + 1) % 3;
                phase = ROW_PENDING;
            end else begin
                c++;
            end
        end else begin
            if (phase == ROW_PENDING && c == 0) phase = ROW_DRAIN;
            if (phase == ROW_DRAIN) begin
                endrow = (c + 1 >= w);
                if (c == 0) add_result(ITEM_MODE, 8'(pend_mode), 1'b0);
                add_result(ITEM_RESIDUAL, residual_at(c), endrow);
                if (endrow) begin
                    phase = ROW_IDLE;
                    c = 0;
                end else begin
                    c++;
                end
            end
        end
        col_pos = c;
        if (result_q.size() > q_mark) result_q[result_q.size() - 1].last_of_run = 1'b1;
    endfunction

    // ---------------- driver ----------------
    int gap_left = 0;

    function automatic int draw_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    always @(posedge i_clk) begin
        t_item nx;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.kind <= KIND_PIXEL;
            in_ch.pixel <= '0;
            in_ch.first_of_frame <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                filter_item('{in_ch.kind, in_ch.pixel, in_ch.first_of_frame});
                gap_left = draw_gap();
            end
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (gap_left > 0 || pixel_q.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    in_ch.valid <= 1'b0;
                end else begin
                    nx = pixel_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.kind <= nx.kind;
                    in_ch.pixel <= nx.pixel;
                    in_ch.first_of_frame <= nx.first;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    int stall_left = 0;
    int idle_cycles = 0;

    task automatic report_mismatch(string what, int exp_v, int got_v);
        $display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected result, queue depth", 0, 1);
                end else begin
                    e = result_q.pop_front();
                    if (out_ch.item_type !== e.item_type)
                        report_mismatch("item_type", e.item_type, out_ch.item_type);
                    if (out_ch.value !== e.value)
                        report_mismatch("value", e.value, out_ch.value);
                    if (out_ch.last_of_run !== e.last_of_run)
                        report_mismatch("last_of_run", e.last_of_run, out_ch.last_of_run);
                    if (out_ch.last_of_frame !== e.last_of_frame)
                        report_mismatch("last_of_frame", e.last_of_frame, out_ch.last_of_frame);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                stall_left = draw_gap();
                out_ch.ready <= (stall_left == 0);
            end
            // watchdog: cycles with no handshake on either channel
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WD_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_width(int unsigned v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_ROW_WIDTH);
        pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cfg_width = v & 13'h1FFF;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // sender holds off until every expected result has arrived
    task automatic wait_drained();
        while (pixel_q.size() != 0 || in_ch.valid || result_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic void push_item(logic k, logic [7:0] p, logic f);
        pixel_q.push_back('{k, p, f});
    endfunction

    // styles: 0 random, 1 constant, 2 horizontal ramp, 3 copy of row above, 4 mixed
    function automatic logic [7:0] pattern_px(int style, int r, int c, int seed);
        case (style)
            1:       return 8'(seed);
            2:       return 8'(seed + c * 3);
            3:       return 8'(seed ^ (c * 37));
            4:       return 8'(seed + r * 11 + c * 5 + $urandom_range(3));
            default: return 8'($urandom);
        endcase
    endfunction

    // a frame of rows, optional full drain; noise adds stray drains mid-row
    function automatic void push_frame(int w, int rows, int style, bit drain, bit noise);
        int seed;
        seed = $urandom_range(255);
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < w; c++) begin
                push_item(KIND_PIXEL, pattern_px(style, r, c, seed), (r == 0 && c == 0));
                if (noise && c + 1 < w && $urandom_range(99) < 4)
                    push_item(KIND_DRAIN, 8'($urandom), 1'($urandom));
            end
        end
        if (drain)
            for (int c = 0; c < w; c++)
                push_item(KIND_DRAIN, 8'($urandom), 1'($urandom));
    endfunction

    initial begin
        int w, ew, r;
        model_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, width 8
        write_width(8);
        push_item(KIND_DRAIN, 8'hFF, 1'b1);          // drain while idle: ignored
        for (int c = 0; c < 8; c++) push_item(KIND_PIXEL, 8'h00, 1'b0);  // idle pixel starts frame
        for (int c = 0; c < 8; c++) push_item(KIND_PIXEL, 8'hFF, c == 3); // restart mid-row
        for (int c = 0; c < 8; c++) push_item(KIND_PIXEL, 8'(c * 32), 1'b0);
        push_item(KIND_DRAIN, 8'h00, 1'b0);
        push_item(KIND_DRAIN, 8'h00, 1'b1);
        push_item(KIND_PIXEL, 8'h80, 1'b0);           // pixel while draining: new frame
        wait_drained();
        for (int s = 1; s < 5; s++) push_frame(9, 3, s, 1'b1, 1'b0);
        wait_drained();

        // width extremes
        write_width(1);
        push_frame(1, 6, 0, 1'b1, 1'b0);
        wait_drained();
        write_width(0);                               // acts as 1
        push_frame(1, 4, 0, 1'b1, 1'b0);
        wait_drained();

        // random phases, small widths
        for (int ph = 0; ph < 5; ph++) begin
            no_gaps = (ph % 4 == 3);
            w = $urandom_range(1, 16);
            write_width(w);
            ew = 0;
            while (ew < 30) begin
                r = $urandom_range(99);
                if (r < 85) begin
                    push_frame(w, $urandom_range(1, 4), $urandom_range(4),
                               $urandom_range(1), 1'b1);
                    ew += w;
                end else begin
                    push_item(1'($urandom), 8'($urandom), 1'($urandom));
                    ew++;
                end
            end
            push_frame(w, 2, $urandom_range(4), 1'b1, 1'b0);
            wait_drained();
        end
        no_gaps = 1'b0;

        wait_drained();
        if (fail_cnt == 0 && result_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
